FILE: rtl/core/rcpa_pkg.sv
// Shared types and codes for the reference counted page allocator.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package rcpa_pkg;

	// Request codes
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_DONATE = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADADR = 2'd1;
	localparam logic [1:0] ST_NOMEM  = 2'd2;
	localparam logic [1:0] ST_UNREF  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_STOP  = 1'b1;

	// Configuration reset values
	localparam logic [31:0] FIRST_RST = 32'h8000_0000;
	localparam logic [32:0] STOP_RST  = 33'h0_8800_0000;

	// Reference count limits
	localparam logic [7:0] REF_MAX = 8'hFF;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rcpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/refcounted_page_allocator.sv
// Top level of the reference counted page allocator.
// Depends on rcpa_pkg and rcpa_ram (link memory and reference count memory).
`default_nettype none

// Page allocator with a last-in first-out free list and an 8-bit reference
// count per page. Each item is one request: allocate pops the list head and
// sets its count to one, free decrements the count and pushes the page when
// it reaches zero, donate adds one reference and then frees. Every item
// yields exactly one result. The free list lives in a link memory and the
// counts in a count memory, both with a registered read; an item is read in
// its accept cycle and written back in EXEC, and the next one is accepted the
// cycle after the write-back, set by the single read-modify-write pass over
// the two memories and the shared list head. A finished result waits in the
// output register while the next item is accepted; an item only waits in its
// write-back cycle if that register still holds a stalled result. After reset
// the block sweeps the count memory to zero, one entry a cycle, and accepts
// no item until the sweep is done (configuration writes are taken throughout).
// Addresses are checked against first_addr and stop_addr; pages are numbered
// from first_addr rounded up to PAGE_BYTES. Configuration is written only
// while no item is in flight: a rule for the user, not enforced by the block.
module refcounted_page_allocator
	import rcpa_pkg::*;
#(
	parameter int PAGES      = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [32:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] page_addr,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  status,
	output logic      [31:0] result_addr,
	output logic      [7:0]  ref_count,
	output logic             released
);

	localparam int IDX_W  = $clog2(PAGES);
	localparam int LINK_W = IDX_W + 1;          // end mark sits above the index
	localparam int PB_LOG = $clog2(PAGE_BYTES);
	localparam int PGW    = 32 - PB_LOG;        // page number width of an address
	localparam int CW     = (PGW + 1 > IDX_W + 1) ? PGW + 1 : IDX_W + 1;
	localparam logic [PGW:0] BASE_PG_RST = (PGW + 1)'(FIRST_RST >> PB_LOG);

	// Configuration
	logic [31:0]  first_addr_q;
	logic [32:0]  stop_addr_q;
	logic [PGW:0] base_pg_q;                    // first_addr rounded up, in pages

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_addr_q <= FIRST_RST;
			stop_addr_q  <= STOP_RST;
			base_pg_q    <= BASE_PG_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FIRST: begin
					first_addr_q <= cfg_data[31:0];
					base_pg_q    <= (PGW + 1)'(cfg_data[31:PB_LOG])
						+ (PGW + 1)'(|cfg_data[PB_LOG-1:0]);
				end
				CFG_STOP: begin
					stop_addr_q <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// Control state
	fsm_state_t        state_q, state_d;
	logic [IDX_W-1:0]  clr_q;
	logic              clr_last;
	logic [IDX_W-1:0]  head_q;
	logic              empty_q;

	// Request registers, loaded at accept
	logic [1:0]        type_s1;
	logic              bad_s1;
	logic [IDX_W-1:0]  idx_s1;

	// Output register
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       result_addr_q;
	logic [7:0]        ref_count_q;
	logic              released_q;

	// Handshake and memory controls
	logic              in_acc;
	logic              go;
	logic              ref_we;
	logic [IDX_W-1:0]  ref_waddr;
	logic [7:0]        ref_wdata;
	logic [7:0]        ref_rdata;
	logic              link_we;
	logic [LINK_W-1:0] link_wdata;
	logic [LINK_W-1:0] link_rdata;

	// Address check on the incoming item; runs in the accept cycle so that the
	// count memory read can be issued at the accept edge.
	logic [PGW:0]      pg_off;
	logic [IDX_W-1:0]  idx_in;
	logic              misaligned;
	logic              below_first;
	logic              past_stop;
	logic              partial;
	logic              out_of_range;
	logic              bad_in;

	assign pg_off       = {1'b0, page_addr[31:PB_LOG]} - base_pg_q;
	assign idx_in       = IDX_W'(pg_off);
	assign misaligned   = |page_addr[PB_LOG-1:0];
	assign below_first  = page_addr < first_addr_q;
	assign past_stop    = {1'b0, page_addr} >= stop_addr_q;
	assign partial      = (req_type == REQ_DONATE)
		&& (({1'b0, page_addr} + 33'(PAGE_BYTES)) > stop_addr_q);
	assign out_of_range = CW'(pg_off) >= CW'(PAGES);
	// aligned and at or above first_addr already means at or above the base
	assign bad_in       = misaligned || below_first || past_stop || partial || out_of_range;

	assign clr_last = (clr_q == IDX_W'(PAGES - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (clr_last) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (in_valid) state_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				if (go) state_d = FSM_IDLE;
			end
			default: state_d = FSM_CLEAR;
		endcase
	end

	// Handshake controls
	always_comb begin
		in_stall = 1'b1;
		go       = 1'b0;
		unique case (state_q)
			FSM_CLEAR: ;
			FSM_IDLE: begin
				in_stall = 1'b0;
			end
			FSM_EXEC: begin
				go = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	assign in_acc = in_valid && !in_stall;

	// Write-back: work out the result and the memory updates from read data
	logic [7:0]     cnt;
	logic [1:0]     ex_status;
	logic [31:0]    ex_addr;
	logic [7:0]     ex_cnt;
	logic           ex_upd;
	logic [7:0]     ex_wdata;
	logic           push;
	logic           pop;
	logic [PGW-1:0] alloc_pg;

	assign cnt      = ref_rdata;
	assign alloc_pg = base_pg_q[PGW-1:0] + PGW'(head_q);

	always_comb begin
		ex_status = ST_OK;
		ex_addr   = '0;
		ex_cnt    = '0;
		ex_upd    = 1'b0;
		ex_wdata  = cnt;
		push      = 1'b0;
		pop       = 1'b0;
		case (type_s1)
			REQ_ALLOC: begin
				if (empty_q) begin
					ex_status = ST_NOMEM;
				end else begin
					pop      = 1'b1;
					ex_addr  = {alloc_pg, {PB_LOG{1'b0}}};
					ex_cnt   = 8'd1;
					ex_upd   = 1'b1;
					ex_wdata = 8'd1;
				end
			end
			REQ_FREE: begin
				if (bad_s1) begin
					ex_status = ST_BADADR;
				end else if (cnt == 8'd0) begin
					ex_status = ST_UNREF;
				end else begin
					ex_wdata = cnt - 8'd1;
					ex_cnt   = cnt - 8'd1;
					ex_upd   = 1'b1;
					push     = (cnt == 8'd1);
				end
			end
			REQ_DONATE: begin
				// add one reference (saturating), then drop one
				if (bad_s1) begin
					ex_status = ST_BADADR;
				end else begin
					ex_wdata = (cnt == REF_MAX) ? REF_MAX - 8'd1 : cnt;
					ex_cnt   = (cnt == REF_MAX) ? REF_MAX - 8'd1 : cnt;
					ex_upd   = 1'b1;
					push     = (cnt == 8'd0);
				end
			end
			default: ;
		endcase
	end

	// Count memory write port: clearing sweep or write-back
	always_comb begin
		ref_we    = 1'b0;
		ref_waddr = idx_s1;
		ref_wdata = ex_wdata;
		if (state_q == FSM_CLEAR) begin
			ref_we    = 1'b1;
			ref_waddr = clr_q;
			ref_wdata = '0;
		end else if (go && ex_upd) begin
			ref_we    = 1'b1;
			ref_waddr = pop ? head_q : idx_s1;
		end
	end

	// Push links the page in front of the current head
	assign link_we    = go && push;
	assign link_wdata = empty_q ? {1'b1, {IDX_W{1'b0}}} : {1'b0, head_q};

	rcpa_ram #(
		.WIDTH (8),
		.DEPTH (PAGES)
	) u_ref_ram (
		.clk     (clk),
		.wr_en   (ref_we),
		.wr_addr (ref_waddr),
		.wr_data (ref_wdata),
		.rd_en   (in_acc),
		.rd_addr (idx_in),
		.rd_data (ref_rdata)
	);

	rcpa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (PAGES)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (idx_s1),
		.wr_data (link_wdata),
		.rd_en   (in_acc),
		.rd_addr (head_q),
		.rd_data (link_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (go && pop) begin
				// end mark set: the list is now empty
				if (link_rdata[IDX_W]) begin
					empty_q <= 1'b1;
					head_q  <= '0;
				end else begin
					head_q <= link_rdata[IDX_W-1:0];
				end
			end else if (go && push) begin
				head_q  <= idx_s1;
				empty_q <= 1'b0;
			end
		end
	end

	// Hold the request fields for the write-back cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			type_s1 <= req_type;
			bad_s1  <= bad_in;
			idx_s1  <= idx_in;
		end
	end

	// Output register: load on write-back, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q      <= ex_status;
			result_addr_q <= ex_addr;
			ref_count_q   <= ex_cnt;
			released_q    <= push;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_addr = result_addr_q;
	assign ref_count   = ref_count_q;
	assign released    = released_q;

endmodule

`default_nettype wire

FILE: rtl/core/rcpa_checker.sv
// Port-level checks for the reference counted page allocator.
// Depends on rcpa_pkg; bound to refcounted_page_allocator at the end of this file.
`default_nettype none

module rcpa_checker
	import rcpa_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [31:0] result_addr,
	input wire logic [7:0]  ref_count,
	input wire logic        released
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(result_addr) && $stable(ref_count) && $stable(released))
		else $error("stalled result changed");

	// one item at a time: the cycle after an accept takes no item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted during write-back");

	// a failed request touches nothing
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_addr == 32'd0 && !released)
		else $error("failed request reports an address or a release");

	// a released page has no references left
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && released |-> status == ST_OK && ref_count == 8'd0
			&& result_addr == 32'd0)
		else $error("release with references left");

	// an allocated page starts with one reference
	a_alloc_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_addr != 32'd0 |-> ref_count == 8'd1)
		else $error("allocated page count is not one");

endmodule

bind refcounted_page_allocator rcpa_checker u_rcpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.result_addr (result_addr),
	.ref_count   (ref_count),
	.released    (released)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for refcounted_page_allocator: free list, reference counts and
// address window. Drives random request traffic against a built-in predictor.
// Depends on rcpa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module testbench;
	import rcpa_pkg::*;

	localparam int PAGES = 32768;
	localparam int PAGE_BYTES = 4096;
	localparam int IDX_W = $clog2(PAGES);
	localparam longint unsigned PB_L = 64'(PAGE_BYTES);
	// end-of-list mark sits just above the page index in a link word
	localparam logic [IDX_W:0] LINK_END = {1'b1, {IDX_W{1'b0}}};
	// request type the block must answer with an all-zero ok result
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
		logic [7:0]  count;
		logic        freed;
	} page_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	// Predictor of the allocator plus the queue of results it still owes.
	class page_ledger;
		longint unsigned window_first = 64'(FIRST_RST);
		longint unsigned window_stop = 64'(STOP_RST);
		logic [IDX_W-1:0] list_head = '0;
		logic list_empty = 1'b1;
		logic [IDX_W:0] links [PAGES];
		logic [7:0] counts [PAGES];
		page_result_t owed_results [$];
		int mismatches = 0;

		function new();
			foreach (counts[i]) counts[i] = '0;
			foreach (links[i]) links[i] = '0;
		endfunction

		function void set_reg(logic index, logic [32:0] value);
			if (index == CFG_FIRST)
				window_first = 64'(value[31:0]);
			else
				window_stop = 64'(value);
		endfunction

		function longint unsigned page_base();
			return ((window_first + PB_L - 1) / PB_L) * PB_L;
		endfunction

		function bit page_of(longint unsigned a, bit donate, output int unsigned idx);
			longint unsigned base_b;
			longint unsigned n;
			base_b = page_base();
			idx = 0;
			if (a % PB_L != 0) return 1'b0;
			if (a < window_first || a >= window_stop || a < base_b) return 1'b0;
			if (donate && a + PB_L > window_stop) return 1'b0;
			n = (a - base_b) / PB_L;
			if (n >= PAGES) return 1'b0;
			idx = 32'(n);
			return 1'b1;
		endfunction

		// Apply one request; return the popped page index, or -1 when nothing was allocated.
		function int predict_request(logic [1:0] kind, logic [31:0] addr);
			page_result_t r;
			int unsigned idx;
			logic [7:0] c;
			longint unsigned full;
			int popped;
			r = '0;
			popped = -1;
			case (kind)
				REQ_ALLOC: begin
					if (list_empty) begin
						r.status = ST_NOMEM;
					end else begin
						idx = 32'(list_head);
						if ((links[idx] & LINK_END) != 0) begin
							list_empty = 1'b1;
							list_head = '0;
						end else begin
							list_head = links[idx][IDX_W-1:0];
						end
						counts[idx] = 8'd1;
						r.count = 8'd1;
						full = page_base() + longint'(idx) * PB_L;
						r.addr = full[31:0];
						popped = int'(idx);
					end
				end
				REQ_FREE, REQ_DONATE: begin
					if (!page_of(64'(addr), kind == REQ_DONATE, idx)) begin
						r.status = ST_BADADR;
					end else begin
						c = counts[idx];
						if (kind == REQ_DONATE && c != REF_MAX) c++;
						if (c == 0) begin
							r.status = ST_UNREF;
						end else begin
							c--;
							counts[idx] = c;
							r.count = c;
							if (c == 0) begin
								// push the page; a page pushed onto an empty list carries the end mark
								links[idx] = list_empty ? LINK_END : {1'b0, list_head};
								list_head = IDX_W'(idx);
								list_empty = 1'b0;
								r.freed = 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
			owed_results.push_back(r);
			return popped;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		task check_result(logic [1:0] st, logic [31:0] adr, logic [7:0] cnt, logic rel);
			page_result_t want;
			if (owed_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = owed_results.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (adr !== want.addr)
				report_mismatch($sformatf("result_addr %h, expected %h", adr, want.addr));
			if (cnt !== want.count)
				report_mismatch($sformatf("ref_count %0d, expected %0d", cnt, want.count));
			if (rel !== want.freed)
				report_mismatch($sformatf("released %b, expected %b", rel, want.freed));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [32:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [31:0] page_addr = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_addr;
	logic [7:0]  ref_count;
	logic        released;

	page_ledger sb = new();
	int unsigned held_pages [$];	// pages this side owns a reference to
	int accepted_items = 0;
	int burst_left = 0;

	// Address windows walked through, extremes among them, and random items per window.
	logic [31:0] first_tab [7] = '{32'h8000_0000, 32'h8000_0123, 32'h0000_0000,
		32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_0000, 32'h8000_0000};
	logic [32:0] stop_tab [7] = '{33'h0_8800_0000, 33'h0_8002_0800, 33'h0_0000_0000,
		33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000, 33'h0_8800_0000};
	int count_tab [7] = '{300, 200, 40, 40, 60, 200, 160};

	refcounted_page_allocator #(
		.PAGES(PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.page_addr(page_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_addr(result_addr),
		.ref_count(ref_count),
		.released(released)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] page_to_addr(int unsigned idx);
		longint unsigned full;
		full = sb.page_base() + longint'(idx) * PB_L;
		return full[31:0];
	endfunction

	// Pick a page-aligned address in the window: mostly a small set of low pages so
	// counts and list links interact, sometimes the last page of the window.
	function automatic logic [31:0] well_formed_addr();
		longint unsigned base_b;
		longint unsigned span;
		base_b = sb.page_base();
		span = (sb.window_stop > base_b) ? (sb.window_stop - base_b) / PB_L : 0;
		if (span > PAGES) span = 64'(PAGES);
		if (span != 0 && $urandom_range(0, 7) == 0) return page_to_addr(32'(span - 1));
		return page_to_addr($urandom_range(0, 23));
	endfunction

	// Offer one item, hold it until accepted, then book its prediction. Keep valid
	// high inside a burst; drop it for a random gap once the burst runs out.
	task automatic offer_request(logic [1:0] kind, logic [31:0] addr);
		int popped;
		in_valid <= 1'b1;
		req_type <= kind;
		page_addr <= addr;
		do @(posedge clk); while (in_stall !== 1'b0);
		popped = sb.predict_request(kind, addr);
		if (popped >= 0) held_pages.push_back(popped);
		accepted_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
		end
	endtask

	// Receiver: stretches of different stall patterns, plus one long hold-off once
	// traffic is flowing so the block backs up and stalls its input.
	initial begin : receiver
		stall_mode_t mode;
		int stretch;
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			if (!hold_done && accepted_items >= 150) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				mode = stall_mode_t'($urandom_range(0, 3));
				stretch = $urandom_range(16, 96);
				repeat (stretch) begin
					case (mode)
						STALL_NONE: out_stall <= 1'b0;
						STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
						STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ~out_stall;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Check every result taken by the receiver against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(status, result_addr, ref_count, released);
	end

	initial begin : stimulus
		int pick;
		int k;
		int noise;
		logic [31:0] addr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 7; ph++) begin
			// write both window registers; the block is idle here
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_FIRST;
			cfg_data <= {1'b0, first_tab[ph]};
			@(posedge clk);
			sb.set_reg(CFG_FIRST, {1'b0, first_tab[ph]});
			cfg_index <= CFG_STOP;
			cfg_data <= stop_tab[ph];
			@(posedge clk);
			sb.set_reg(CFG_STOP, stop_tab[ph]);
			cfg_wr_en <= 1'b0;

			if (ph == 0) begin
				// empty list, unreferenced free, then populate the list
				offer_request(REQ_ALLOC, 32'h0000_0000);
				offer_request(REQ_FREE, 32'h8000_0000);
				offer_request(REQ_DONATE, 32'h8000_0000);
				offer_request(REQ_DONATE, 32'h87FF_F000);
				offer_request(REQ_DONATE, 32'h8000_1000);
				// bad addresses: misaligned, below, at stop, far above, zero
				offer_request(REQ_DONATE, 32'h8000_0800);
				offer_request(REQ_FREE, 32'h7FFF_F000);
				offer_request(REQ_FREE, 32'h8800_0000);
				offer_request(REQ_DONATE, 32'hFFFF_F000);
				offer_request(REQ_FREE, 32'h0000_0000);
				offer_request(REQ_UNKNOWN, 32'hFFFF_FFFF);
				// pop, donate while referenced, free back, then a double push
				offer_request(REQ_ALLOC, 32'hFFFF_FFFF);
				offer_request(REQ_DONATE, 32'h8000_1000);
				offer_request(REQ_FREE, 32'h8000_1000);
				offer_request(REQ_DONATE, 32'h8000_0000);
				offer_request(REQ_ALLOC, 32'h0000_0000);
				offer_request(REQ_ALLOC, 32'h0000_0000);
				offer_request(REQ_ALLOC, 32'h0000_0000);
				offer_request(REQ_FREE, 32'h8000_0000);
			end
			if (ph == 1) begin
				// unaligned first and stop: partial last page, page below the rounded base
				offer_request(REQ_DONATE, 32'h8002_0000);
				offer_request(REQ_FREE, 32'h8002_0000);
				offer_request(REQ_DONATE, 32'h8000_0000);
			end

			repeat (count_tab[ph]) begin
				pick = $urandom_range(0, 99);
				if (pick < 34) begin
					offer_request(REQ_ALLOC, $urandom());
				end else if (pick < 62 && held_pages.size() != 0) begin
					// release a page we hold, in random order
					k = $urandom_range(0, held_pages.size() - 1);
					addr = page_to_addr(held_pages[k]);
					held_pages.delete(k);
					offer_request(REQ_FREE, addr);
				end else if (pick < 82) begin
					offer_request(REQ_DONATE, well_formed_addr());
				end else if (pick < 88) begin
					offer_request(REQ_FREE, well_formed_addr());
				end else if (pick < 98) begin
					// noise: random, misaligned, just outside or at the window edges
					noise = $urandom_range(0, 5);
					if (noise == 0)
						addr = $urandom();
					else if (noise == 1)
						addr = well_formed_addr() + $urandom_range(1, PAGE_BYTES - 1);
					else if (noise == 2)
						addr = page_to_addr(0) - PAGE_BYTES;
					else if (noise == 3)
						addr = sb.window_stop[31:0];
					else if (noise == 4)
						addr = 32'((sb.window_stop - 1) & ~(PB_L - 1));
					else
						addr = sb.window_first[31:0];
					offer_request(($urandom_range(0, 1) != 0) ? REQ_FREE : REQ_DONATE, addr);
				end else begin
					offer_request(REQ_UNKNOWN, $urandom());
				end
			end

			// drain: wait for every owed result, then let the block settle
			in_valid <= 1'b0;
			while (sb.owed_results.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
		end

		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Covers the clearing sweep after reset and the slowest stall pattern many times over.
	initial begin : watchdog
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
